FILE: design/ecc_pkg.sv
package ecc_pkg;

    // Calendar constants
    localparam int FIRST_YEAR   = 70;
    localparam int LAST_YEAR    = 99;
    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HR  = 3600;
    localparam int SECS_PER_MIN = 60;

    // Reciprocals for the divisions by 86400, 3600 and 60. The power-of-two factor of each
    // divisor is shifted out first, leaving divisions by 675, 225 and 15 of dividends of at
    // most 23, 13 and 10 bits. The reciprocals are rounded up from 2^32/675, 2^20/225 and
    // 2^14/15, which keeps the quotient exact over the values that each dividend takes here.
    localparam logic [22:0] DAY_RECIP  = 23'd6362915;
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam logic [32:0] MASK30 = 33'h0_3FFF_FFFF;

    typedef logic [4:0] pc_t;

    // Program addresses
    localparam pc_t PC_OP0    = 5'd0;
    localparam pc_t PC_YEAR0  = 5'd1;
    localparam pc_t PC_OP1    = 5'd8;
    localparam pc_t PC_YEAR1  = 5'd15;
    localparam pc_t PC_MONTH  = 5'd17;
    localparam pc_t PC_DONE   = 5'd19;

    typedef enum logic [4:0] {
        OP_CHK0,
        OP_YEAR0,
        OP_DAYS0,
        OP_MULD,
        OP_ACCH,
        OP_ACCM,
        OP_ACCS,
        OP_OVF,
        OP_DIVLD,
        OP_QDAY,
        OP_RDAY,
        OP_QHR,
        OP_RHR,
        OP_QMIN,
        OP_RMIN,
        OP_YEAR1,
        OP_YCHK,
        OP_MONTH,
        OP_DOM,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_MORE,
        C_ERR,
        C_ALWAYS
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic in_load;
        logic step_en;
    } seq_ctl_t;

    typedef struct packed {
        logic more;
        logic err_now;
    } dp_status_t;

    // Day of year on which month index m begins; indexes above 11 clamp to December.
    function automatic logic [8:0] month_start(input logic [7:0] y, input logic [3:0] m);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            default: base = 9'd334;
        endcase
        if ((y[1:0] == 2'b00) && (m > 4'd1)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    function automatic logic [8:0] year_length(input logic [7:0] y);
        return (y[1:0] == 2'b00) ? 9'd366 : 9'd365;
    endfunction

endpackage

FILE: design/ecc_ucode_rom.sv
module ecc_ucode_rom
    import ecc_pkg::*;
(
    input  pc_t   pc,
    output ctrl_t ctrl
);

    always_comb begin
        unique case (pc)
            // Calendar fields to seconds
            5'd0:  ctrl = '{op: OP_CHK0,  cond: C_ERR,    target: PC_DONE};
            5'd1:  ctrl = '{op: OP_YEAR0, cond: C_MORE,   target: PC_YEAR0};
            5'd2:  ctrl = '{op: OP_DAYS0, cond: C_NEXT,   target: PC_DONE};
            5'd3:  ctrl = '{op: OP_MULD,  cond: C_NEXT,   target: PC_DONE};
            5'd4:  ctrl = '{op: OP_ACCH,  cond: C_NEXT,   target: PC_DONE};
            5'd5:  ctrl = '{op: OP_ACCM,  cond: C_NEXT,   target: PC_DONE};
            5'd6:  ctrl = '{op: OP_ACCS,  cond: C_NEXT,   target: PC_DONE};
            5'd7:  ctrl = '{op: OP_OVF,   cond: C_ALWAYS, target: PC_DONE};
            // Seconds to calendar fields
            5'd8:  ctrl = '{op: OP_DIVLD, cond: C_NEXT,   target: PC_DONE};
            5'd9:  ctrl = '{op: OP_QDAY,  cond: C_NEXT,   target: PC_DONE};
            5'd10: ctrl = '{op: OP_RDAY,  cond: C_NEXT,   target: PC_DONE};
            5'd11: ctrl = '{op: OP_QHR,   cond: C_NEXT,   target: PC_DONE};
            5'd12: ctrl = '{op: OP_RHR,   cond: C_NEXT,   target: PC_DONE};
            5'd13: ctrl = '{op: OP_QMIN,  cond: C_NEXT,   target: PC_DONE};
            5'd14: ctrl = '{op: OP_RMIN,  cond: C_NEXT,   target: PC_DONE};
            5'd15: ctrl = '{op: OP_YEAR1, cond: C_MORE,   target: PC_YEAR1};
            5'd16: ctrl = '{op: OP_YCHK,  cond: C_ERR,    target: PC_DONE};
            5'd17: ctrl = '{op: OP_MONTH, cond: C_MORE,   target: PC_MONTH};
            5'd18: ctrl = '{op: OP_DOM,   cond: C_NEXT,   target: PC_DONE};
            default: ctrl = '{op: OP_DONE, cond: C_NEXT,  target: PC_DONE};
        endcase
    end

endmodule

FILE: design/ecc_sequencer.sv
module ecc_sequencer
    import ecc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_operation,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  ctrl_t      ctrl,
    input  dp_status_t status,
    output pc_t        pc,
    output seq_ctl_t   seq_ctl
);

    pc_t  pc_reg, pc_next;
    logic busy_reg, busy_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic step_en;
    logic done_fire;

    assign accept    = s_tvalid && !busy_reg;
    // The final step holds while the previous result still waits downstream.
    assign step_en   = busy_reg &&
                       !((ctrl.op == OP_DONE) && out_valid_reg && !m_tready);
    assign done_fire = step_en && (ctrl.op == OP_DONE);

    always_comb begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            pc_next   = s_operation ? PC_OP1 : PC_OP0;
        end else if (done_fire) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end else if (step_en) begin
            case (ctrl.cond)
                C_MORE:   pc_next = status.more ? ctrl.target : pc_reg + 5'd1;
                C_ERR:    pc_next = status.err_now ? ctrl.target : pc_reg + 5'd1;
                C_ALWAYS: pc_next = ctrl.target;
                default:  pc_next = pc_reg + 5'd1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= PC_OP0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready        = !busy_reg;
    assign m_tvalid        = out_valid_reg;
    assign pc              = pc_reg;
    assign seq_ctl.in_load = accept;
    assign seq_ctl.step_en = step_en;

endmodule

FILE: design/ecc_datapath.sv
module ecc_datapath
    import ecc_pkg::*;
(
    input  logic        aclk,
    input  logic [63:0] s_tdata,
    input  logic        s_operation,
    input  ctrl_t       ctrl,
    input  seq_ctl_t    seq_ctl,
    output dp_status_t  status,
    output logic [63:0] m_tdata,
    output logic        m_range_error
);

    // Captured input item
    logic        op_reg;
    logic [29:0] secs_in_reg;
    logic [6:0]  year_in_reg;
    logic [3:0]  month_in_reg;
    logic [4:0]  day_in_reg;
    logic [4:0]  hour_in_reg;
    logic [5:0]  minute_in_reg;
    logic [5:0]  second_in_reg;

    // Working registers
    logic [7:0]  y_reg, y_next;
    logic [15:0] days_reg, days_next;
    logic [3:0]  m_reg, m_next;
    logic [32:0] acc_reg, acc_next;
    logic [32:0] prod_reg, prod_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  dom_reg, dom_next;
    logic        err_reg, err_next;

    // Result register
    logic [63:0] out_data_reg;
    logic        out_err_reg;
    logic [63:0] out_data_next;

    logic        range_bad;
    logic [8:0]  ylen;
    logic [8:0]  som_next_month;

    // Quotient products and the multiples that are taken back off for the remainders
    logic [45:0] day_quot_prod;
    logic [24:0] hour_quot_prod;
    logic [19:0] min_quot_prod;
    logic [30:0] day_back;
    logic [16:0] hour_back;
    logic [11:0] min_back;

    assign ylen           = year_length(y_reg);
    assign som_next_month = month_start(y_reg, m_reg + 4'd1);

    assign day_quot_prod  = 46'(acc_reg[29:7]) * 46'(DAY_RECIP);
    assign hour_quot_prod = 25'(acc_reg[16:4]) * 25'(HOUR_RECIP);
    assign min_quot_prod  = 20'(acc_reg[11:2]) * 20'(MIN_RECIP);
    assign day_back       = 31'(days_reg[13:0]) * 31'(SECS_PER_DAY);
    assign hour_back      = 17'(hour_reg) * 17'(SECS_PER_HR);
    assign min_back       = 12'(min_reg) * 12'(SECS_PER_MIN);

    assign range_bad = (year_in_reg < 7'(FIRST_YEAR)) || (8'(year_in_reg) > 8'(LAST_YEAR)) ||
                       (month_in_reg == 4'd0) || (month_in_reg > 4'd12) ||
                       (day_in_reg == 5'd0) || (hour_in_reg > 5'd23) ||
                       (minute_in_reg > 6'd59) || (second_in_reg > 6'd59);

    always_comb begin
        status.more    = 1'b0;
        status.err_now = 1'b0;
        unique case (ctrl.op)
            OP_CHK0:  status.err_now = range_bad;
            OP_YEAR0: status.more    = y_reg < 8'(year_in_reg);
            OP_OVF:   status.err_now = acc_reg > MASK30;
            OP_YEAR1: status.more    = days_reg >= 16'(ylen);
            OP_YCHK:  status.err_now = y_reg > 8'(LAST_YEAR);
            OP_MONTH: status.more    = (m_reg < 4'd11) && (16'(som_next_month) <= days_reg);
            default: begin
                status.more    = 1'b0;
                status.err_now = 1'b0;
            end
        endcase
    end

    always_comb begin
        y_next        = y_reg;
        days_next     = days_reg;
        m_next        = m_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        hour_next     = hour_reg;
        min_next      = min_reg;
        dom_next      = dom_reg;
        err_next      = err_reg;
        out_data_next = 64'd0;
        if (!err_reg) begin
            if (!op_reg) begin
                out_data_next[29:0] = acc_reg[29:0];
            end else begin
                out_data_next[36:30] = y_reg[6:0];
                out_data_next[40:37] = m_reg + 4'd1;
                out_data_next[45:41] = dom_reg;
                out_data_next[50:46] = hour_reg;
                out_data_next[56:51] = min_reg;
                out_data_next[62:57] = acc_reg[5:0];
            end
        end
        unique case (ctrl.op)
            OP_CHK0: begin
                y_next    = 8'(FIRST_YEAR);
                days_next = 16'd0;
                err_next  = range_bad;
            end
            OP_YEAR0: begin
                if (status.more) begin
                    days_next = days_reg + 16'(ylen);
                    y_next    = y_reg + 8'd1;
                end
            end
            OP_DAYS0: begin
                days_next = days_reg + 16'(month_start({1'b0, year_in_reg}, month_in_reg - 4'd1))
                            + 16'(day_in_reg) - 16'd1;
            end
            OP_MULD: prod_next = 33'(days_reg) * 33'(SECS_PER_DAY);
            OP_ACCH: begin
                acc_next  = prod_reg;
                prod_next = 33'(hour_in_reg) * 33'(SECS_PER_HR);
            end
            OP_ACCM: begin
                acc_next  = acc_reg + prod_reg;
                prod_next = 33'(minute_in_reg) * 33'(SECS_PER_MIN);
            end
            OP_ACCS: acc_next = acc_reg + prod_reg + 33'(second_in_reg);
            OP_OVF:  err_next = status.err_now;
            OP_DIVLD: begin
                acc_next = 33'(secs_in_reg);
                err_next = 1'b0;
                y_next   = 8'(FIRST_YEAR);
                m_next   = 4'd0;
            end
            OP_QDAY: days_next = {2'b00, day_quot_prod[45:32]};
            OP_RDAY: acc_next  = acc_reg - 33'(day_back);
            OP_QHR:  hour_next = hour_quot_prod[24:20];
            OP_RHR:  acc_next  = acc_reg - 33'(hour_back);
            OP_QMIN: min_next  = min_quot_prod[19:14];
            OP_RMIN: acc_next  = acc_reg - 33'(min_back);
            OP_YEAR1: begin
                if (status.more) begin
                    days_next = days_reg - 16'(ylen);
                    y_next    = y_reg + 8'd1;
                end
            end
            OP_YCHK:  err_next = status.err_now;
            OP_MONTH: begin
                if (status.more) begin
                    m_next = m_reg + 4'd1;
                end
            end
            OP_DOM: dom_next = 5'(days_reg - 16'(month_start(y_reg, m_reg)) + 16'd1);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (seq_ctl.in_load) begin
            op_reg        <= s_operation;
            secs_in_reg   <= s_tdata[29:0];
            year_in_reg   <= s_tdata[36:30];
            month_in_reg  <= s_tdata[40:37];
            day_in_reg    <= s_tdata[45:41];
            hour_in_reg   <= s_tdata[50:46];
            minute_in_reg <= s_tdata[56:51];
            second_in_reg <= s_tdata[62:57];
        end
        if (seq_ctl.step_en) begin
            y_reg    <= y_next;
            days_reg <= days_next;
            m_reg    <= m_next;
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
            hour_reg <= hour_next;
            min_reg  <= min_next;
            dom_reg  <= dom_next;
            err_reg  <= err_next;
            if (ctrl.op == OP_DONE) begin
                out_data_reg <= out_data_next;
                out_err_reg  <= err_reg;
            end
        end
    end

    assign m_tdata       = out_data_reg;
    assign m_range_error = out_err_reg;

endmodule

FILE: design/epoch_calendar_converter_unit.sv
// Epoch calendar converter.
// Input channel s_*: s_tuser carries the operation (0 = calendar fields to seconds,
// 1 = seconds to calendar fields); s_tdata carries the operands. Result channel m_*:
// m_tdata carries the converted fields and m_tuser the range error flag, with every
// other field zero when it is set. Each item gives exactly one result item.
// Work is done by a microprogram of twenty steps stepping a single shared datapath;
// the step counter visits one control word per cycle unless the last step is held,
// and the year and month loops repeat their own step. Each division by 86400, 3600
// or 60 is a reciprocal multiplication of one step, followed by one step that takes
// off the remainder. A field error or a count past the last year ends the work early.
// One item is worked on at a time: s_tready is high whenever no item is in work,
// so a new item is taken in the cycle after the previous one finishes, even while
// its result still waits in the output register. If the receiver stalls with a
// result still held, the last step of the next item waits until m_tready frees the
// output register. After reset both channels are empty and s_tready is high.
module epoch_calendar_converter_unit
    import ecc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [29:0] seconds_in, [36:30] year_in, [40:37] month_in, [45:41] day_in,
    // [50:46] hour_in, [56:51] minute_in, [62:57] second_in, [63] zero
    input  logic [63:0] s_tdata,
    // [0] operation
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [29:0] seconds_out, [36:30] year_out, [40:37] month_out, [45:41] day_out,
    // [50:46] hour_out, [56:51] minute_out, [62:57] second_out, [63] zero
    output logic [63:0] m_tdata,
    // [0] range_error
    output logic [0:0]  m_tuser
);

    pc_t        pc;
    ctrl_t      ctrl;
    seq_ctl_t   seq_ctl;
    dp_status_t status;
    logic       range_error;

    ecc_ucode_rom u_rom (
        .pc   (pc),
        .ctrl (ctrl)
    );

    ecc_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_operation (s_tuser[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .ctrl        (ctrl),
        .status      (status),
        .pc          (pc),
        .seq_ctl     (seq_ctl)
    );

    ecc_datapath u_dp (
        .aclk          (aclk),
        .s_tdata       (s_tdata),
        .s_operation   (s_tuser[0]),
        .ctrl          (ctrl),
        .seq_ctl       (seq_ctl),
        .status        (status),
        .m_tdata       (m_tdata),
        .m_range_error (range_error)
    );

    assign m_tuser[0] = range_error;

endmodule

FILE: tb/tb_epoch_calendar_converter_unit.sv
module tb_epoch_calendar_converter_unit;

    localparam int unsigned FIRST_YR   = 70;
    localparam int unsigned LAST_YR    = 99;
    localparam int unsigned SECS_DAY   = 86400;
    localparam int unsigned SECS_HOUR  = 3600;
    localparam int unsigned SECS_MIN   = 60;
    localparam int unsigned MAX_SECS   = 946684799;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned LONG_HOLD    = 400;

    typedef enum bit {
        TO_SECONDS  = 1'b0,
        TO_CALENDAR = 1'b1
    } conv_dir_t;

    typedef struct packed {
        conv_dir_t dir;
        bit [29:0] seconds;
        bit [6:0]  year;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
    } conv_req_t;

    typedef struct packed {
        bit [29:0] seconds;
        bit [6:0]  year;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
        bit        range_error;
    } conv_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    conv_req_t requests_pending[$];
    conv_res_t dates_due[$];
    int unsigned fail_count = 0;

    epoch_calendar_converter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned year_days(int unsigned y);
        return (y % 4 == 0) ? 366 : 365;
    endfunction

    // First day of month m (0 = January) counted from the start of year y.
    function automatic int unsigned month_first_day(int unsigned y, int unsigned m);
        int unsigned d;
        case (m)
            0:       d = 0;
            1:       d = 31;
            2:       d = 59;
            3:       d = 90;
            4:       d = 120;
            5:       d = 151;
            6:       d = 181;
            7:       d = 212;
            8:       d = 243;
            9:       d = 273;
            10:      d = 304;
            default: d = 334;
        endcase
        if (y % 4 == 0 && m > 1) begin
            d = d + 1;
        end
        return d;
    endfunction

    function automatic conv_res_t convert_date(conv_req_t q);
        conv_res_t r;
        longint unsigned days;
        longint unsigned total;
        int unsigned y;
        int unsigned m;
        int unsigned rest;
        r = '0;
        days = 0;
        m = 0;
        y = FIRST_YR;
        if (q.dir == TO_SECONDS) begin
            if (q.year < FIRST_YR || q.year > LAST_YR || q.month < 1 || q.month > 12 ||
                q.day < 1 || q.hour > 23 || q.minute > 59 || q.second > 59) begin
                r.range_error = 1'b1;
            end else begin
                for (y = FIRST_YR; y < q.year; y++) begin
                    days += year_days(y);
                end
                days += month_first_day(q.year, q.month - 1) + q.day - 1;
                total = days * SECS_DAY + q.hour * SECS_HOUR + q.minute * SECS_MIN + q.second;
                if (total > 64'h3FFF_FFFF) begin
                    r.range_error = 1'b1;
                end else begin
                    r.seconds = total[29:0];
                end
            end
        end else begin
            days = q.seconds / SECS_DAY;
            rest = q.seconds % SECS_DAY;
            while (days >= year_days(y)) begin
                days -= year_days(y);
                y++;
            end
            if (y > LAST_YR) begin
                r.range_error = 1'b1;
            end else begin
                // December is the last candidate, so the search never runs off the table.
                while (m < 11 && month_first_day(y, m + 1) <= days) begin
                    m++;
                end
                r.year   = 7'(y);
                r.month  = 4'(m + 1);
                r.day    = 5'(days - month_first_day(y, m) + 1);
                r.hour   = 5'(rest / SECS_HOUR);
                r.minute = 6'((rest % SECS_HOUR) / SECS_MIN);
                r.second = 6'(rest % SECS_MIN);
            end
        end
        return r;
    endfunction

    function automatic conv_req_t calendar_req(int unsigned y, int unsigned mo, int unsigned d,
                                               int unsigned h, int unsigned mi, int unsigned s);
        conv_req_t q;
        q.dir     = TO_SECONDS;
        q.seconds = 30'($urandom);
        q.year    = 7'(y);
        q.month   = 4'(mo);
        q.day     = 5'(d);
        q.hour    = 5'(h);
        q.minute  = 6'(mi);
        q.second  = 6'(s);
        return q;
    endfunction

    function automatic conv_req_t seconds_req(int unsigned secs);
        conv_req_t q;
        q = conv_req_t'({$urandom, $urandom, $urandom});
        q.dir     = TO_CALENDAR;
        q.seconds = 30'(secs);
        return q;
    endfunction

    // Sender: one item in flight on the bus, with a drawn pause after each acceptance.
    conv_req_t offered;
    int unsigned send_gap = 0;
    int unsigned sent_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                dates_due.push_back(convert_date(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap = send_gap - 1;
                end else if (requests_pending.size() > 0) begin
                    offered = requests_pending.pop_front();
                    s_tdata <= {1'b0, offered.second, offered.minute, offered.hour,
                                offered.day, offered.month, offered.year, offered.seconds};
                    s_tuser <= offered.dir;
                    s_tvalid <= 1'b1;
                    sent_count = sent_count + 1;
                    send_gap = (sent_count % 300 < 50) ? 0 : $urandom_range(0, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result item and draws how long to hold m_tready low.
    conv_res_t got;
    conv_res_t want;
    int unsigned ready_wait = 0;
    int unsigned results_seen = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[29:0], m_tdata[36:30], m_tdata[40:37], m_tdata[45:41],
                       m_tdata[50:46], m_tdata[56:51], m_tdata[62:57], m_tuser[0]};
                if (dates_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("unexpected result item: secs=%0d %0d/%0d/%0d %0d:%0d:%0d err=%0d",
                                 got.seconds, got.year, got.month, got.day,
                                 got.hour, got.minute, got.second, got.range_error);
                    end
                end else begin
                    want = dates_due.pop_front();
                    if (got.seconds !== want.seconds || got.year !== want.year ||
                        got.month !== want.month || got.day !== want.day ||
                        got.hour !== want.hour || got.minute !== want.minute ||
                        got.second !== want.second || got.range_error !== want.range_error) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("mismatch on result %0d: expected secs=%0d %0d/%0d/%0d %0d:%0d:%0d err=%0d",
                                     results_seen, want.seconds, want.year, want.month, want.day,
                                     want.hour, want.minute, want.second, want.range_error);
                            $display("    actual secs=%0d %0d/%0d/%0d %0d:%0d:%0d err=%0d",
                                     got.seconds, got.year, got.month, got.day,
                                     got.hour, got.minute, got.second, got.range_error);
                        end
                    end
                end
                results_seen = results_seen + 1;
                // Two long hold-offs let the block fill up and push back on its input.
                if (results_seen == 40 || results_seen == 1000) begin
                    ready_wait = LONG_HOLD;
                end else if (results_seen % 250 < 40) begin
                    ready_wait = 0;
                end else begin
                    ready_wait = $urandom_range(0, 6);
                end
            end
            if (ready_wait > 0) begin
                m_tready <= 1'b0;
                ready_wait = ready_wait - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        conv_req_t q;
        int unsigned kind;
        int unsigned i;

        // Directed: range limits, leap years, December and every error condition.
        requests_pending.push_back(calendar_req(70, 1, 1, 0, 0, 0));
        requests_pending.push_back(calendar_req(99, 12, 31, 23, 59, 59));
        requests_pending.push_back(calendar_req(72, 2, 29, 12, 34, 56));
        requests_pending.push_back(calendar_req(73, 2, 31, 1, 2, 3));
        requests_pending.push_back(calendar_req(96, 12, 31, 23, 59, 59));
        requests_pending.push_back(calendar_req(69, 6, 15, 10, 10, 10));
        requests_pending.push_back(calendar_req(100, 6, 15, 10, 10, 10));
        requests_pending.push_back(calendar_req(0, 1, 1, 0, 0, 0));
        requests_pending.push_back(calendar_req(127, 15, 31, 31, 63, 63));
        requests_pending.push_back(calendar_req(80, 0, 10, 5, 5, 5));
        requests_pending.push_back(calendar_req(80, 13, 10, 5, 5, 5));
        requests_pending.push_back(calendar_req(80, 5, 0, 5, 5, 5));
        requests_pending.push_back(calendar_req(80, 5, 10, 24, 5, 5));
        requests_pending.push_back(calendar_req(80, 5, 10, 5, 60, 5));
        requests_pending.push_back(calendar_req(80, 5, 10, 5, 5, 60));
        requests_pending.push_back(seconds_req(0));
        requests_pending.push_back(seconds_req(MAX_SECS));
        requests_pending.push_back(seconds_req(MAX_SECS + 1));
        requests_pending.push_back(seconds_req(30'h3FFF_FFFF));
        requests_pending.push_back(seconds_req(68169600));
        requests_pending.push_back(seconds_req(94694399));
        requests_pending.push_back(seconds_req(94694400));
        requests_pending.push_back(seconds_req(31535999));

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 42) begin
                q = calendar_req($urandom_range(FIRST_YR, LAST_YR), $urandom_range(1, 12),
                                 $urandom_range(1, 31), $urandom_range(0, 23),
                                 $urandom_range(0, 59), $urandom_range(0, 59));
            end else if (kind < 50) begin
                // Raw fields over their whole encoded range, mostly out of range.
                q = conv_req_t'({$urandom, $urandom, $urandom});
                q.dir = TO_SECONDS;
            end else if (kind < 92) begin
                q = seconds_req($urandom_range(0, MAX_SECS));
            end else begin
                q = seconds_req($urandom);
            end
            requests_pending.push_back(q);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_pending.size() > 0 || s_tvalid || dates_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (120) @(posedge aclk);

        if (fail_count == 0 && dates_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
